// ----- src/pss_pkg.sv -----
`timescale 1ns / 1ps

package pss_pkg;

    localparam int SAMPLE_W = 10;
    localparam int SPEED_W  = 8;
    localparam int SERVO_W  = 7;
    localparam int LED_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Scaled product of gain/4 and position excess: 8 x 10 bits.
    localparam int PROD_W = 18;

    // Exact reciprocal for x / 212 with x below 2**18: (x * 316552) >> 26.
    localparam int SPEED_RECIP_W = 19;
    localparam logic [SPEED_RECIP_W-1:0] SPEED_RECIP = 19'd316552;
    localparam int SPEED_SHIFT = 26;
    localparam int SPEED_Q_W = 11;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

    // floor(speed * 35 / 255) folded into one multiply: (speed * 575715) >> 22.
    localparam int SERVO_RECIP_W = 20;
    localparam logic [SERVO_RECIP_W-1:0] SERVO_RECIP = 20'd575715;
    localparam int SERVO_SHIFT = 22;
    localparam int SERVO_Q_W = 6;
    localparam logic [SERVO_W-1:0] SERVO_BASE = 7'd50;
    localparam logic [SERVO_W-1:0] SERVO_TOP  = 7'd85;

    localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST  = 10'd220;
    localparam logic [SAMPLE_W-1:0] CLEAR_LEVEL_RST  = 10'd425;
    localparam logic [SAMPLE_W-1:0] FIRST_LEVEL_RST  = 10'd420;
    localparam logic [SAMPLE_W-1:0] SECOND_LEVEL_RST = 10'd370;
    localparam logic [SAMPLE_W-1:0] THIRD_LEVEL_RST  = 10'd310;
    localparam logic [SAMPLE_W-1:0] ALARM_LEVEL_RST  = 10'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET  = 3'd0,
        CFG_CLEAR_LEVEL  = 3'd1,
        CFG_FIRST_LEVEL  = 3'd2,
        CFG_SECOND_LEVEL = 3'd3,
        CFG_THIRD_LEVEL  = 3'd4,
        CFG_ALARM_LEVEL  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] clear_level;
        logic [SAMPLE_W-1:0] first_level;
        logic [SAMPLE_W-1:0] second_level;
        logic [SAMPLE_W-1:0] third_level;
        logic [SAMPLE_W-1:0] alarm_level;
    } levels_t;

    typedef struct packed {
        logic [LED_W-1:0] bits;
        logic             alarm;
    } led_status_t;

endpackage

// ----- src/pss_if.sv -----
`timescale 1ns / 1ps

interface pss_sample_if;
    logic                          valid;
    logic                          ready;
    logic [pss_pkg::SAMPLE_W-1:0]  pos_sample;
    logic [pss_pkg::SAMPLE_W-1:0]  gain_sample;

    modport source (output valid, output pos_sample, output gain_sample, input ready);
    modport sink   (input valid, input pos_sample, input gain_sample, output ready);
endinterface

interface pss_result_if;
    logic                          valid;
    logic                          ready;
    logic [pss_pkg::SAMPLE_W-1:0]  pos_average;
    logic [pss_pkg::SAMPLE_W-1:0]  gain_average;
    logic [pss_pkg::SPEED_W-1:0]   speed_duty;
    logic [pss_pkg::SERVO_W-1:0]   servo_compare;
    logic [pss_pkg::LED_W-1:0]     led_bits;
    logic                          alarm_blink;

    modport source (output valid, output pos_average, output gain_average,
                    output speed_duty, output servo_compare, output led_bits,
                    output alarm_blink, input ready);
    modport sink   (input valid, input pos_average, input gain_average,
                    input speed_duty, input servo_compare, input led_bits,
                    input alarm_blink, output ready);
endinterface

// ----- src/pedal_speed_scaler_with_led_bar.sv -----
`timescale 1ns / 1ps
// The item completing a group of SAMPLES pairs moves its totals into the first stage.
// Throughput: one item per cycle, but a group's closing item waits for room in the
// first stage; one result per SAMPLES items. The group total, average, product,
// speed and servo stages each hold one register stage.
// Reset (rst_n, asynchronous, active low): totals, pair count, LED bar and all
// stage valid bits clear; configuration registers return to their defaults.

module pedal_speed_scaler_with_led_bar
#(
    parameter int SAMPLES = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    pss_sample_if.sink                     samples,
    pss_result_if.source                   results,
    input  logic                           cfg_we,
    input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pss_pkg::SAMPLE_W-1:0]   cfg_data
);

    // Group totals never overflow: they are sized for SAMPLES full-scale samples.
    localparam int TOT_W = $clog2(SAMPLES * 1023 + 1);
    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(SAMPLES - 1);

    // Averages use an exact reciprocal: for totals below 2**TOT_W,
    // total / SAMPLES == (total * AVG_RECIP) >> AVG_SHIFT.
    localparam int AVG_L     = (SAMPLES > 1) ? $clog2(SAMPLES) : 0;
    localparam int AVG_SHIFT = TOT_W + AVG_L;
    localparam int AVG_P_W   = 2 * TOT_W + 1;
    localparam logic [TOT_W:0] AVG_RECIP =
        (TOT_W + 1)'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

    localparam int SP_P_W = pss_pkg::PROD_W + pss_pkg::SPEED_RECIP_W;
    localparam int SV_P_W = pss_pkg::SPEED_W + pss_pkg::SERVO_RECIP_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes beyond the last index are dropped.
    // ------------------------------------------------------------------
    logic [pss_pkg::SAMPLE_W-1:0] zero_offset_reg;
    pss_pkg::levels_t             levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg         <= pss_pkg::ZERO_OFFSET_RST;
            levels_reg.clear_level  <= pss_pkg::CLEAR_LEVEL_RST;
            levels_reg.first_level  <= pss_pkg::FIRST_LEVEL_RST;
            levels_reg.second_level <= pss_pkg::SECOND_LEVEL_RST;
            levels_reg.third_level  <= pss_pkg::THIRD_LEVEL_RST;
            levels_reg.alarm_level  <= pss_pkg::ALARM_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (pss_pkg::cfg_idx_t'(cfg_index))
                pss_pkg::CFG_ZERO_OFFSET:  zero_offset_reg         <= cfg_data;
                pss_pkg::CFG_CLEAR_LEVEL:  levels_reg.clear_level  <= cfg_data;
                pss_pkg::CFG_FIRST_LEVEL:  levels_reg.first_level  <= cfg_data;
                pss_pkg::CFG_SECOND_LEVEL: levels_reg.second_level <= cfg_data;
                pss_pkg::CFG_THIRD_LEVEL:  levels_reg.third_level  <= cfg_data;
                pss_pkg::CFG_ALARM_LEVEL:  levels_reg.alarm_level  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage moves forward when it is empty or when the
    // stage after it moves, so bubbles collapse and the output register
    // acts as the skid between the pipeline and the consumer.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_adv, s2_adv, s3_adv, s4_adv, out_adv;

    assign out_adv = !out_valid_reg || results.ready;
    assign s4_adv  = !s4_valid_reg || out_adv;
    assign s3_adv  = !s3_valid_reg || s4_adv;
    assign s2_adv  = !s2_valid_reg || s3_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;

    // ------------------------------------------------------------------
    // Accumulation. Items that do not close a group are always taken; the
    // closing item needs room in the first stage.
    // ------------------------------------------------------------------
    logic [TOT_W-1:0] pos_total_reg, gain_total_reg;
    logic [CNT_W-1:0] pair_count_reg;
    logic [TOT_W-1:0] pos_sum, gain_sum;
    logic             last_pair;
    logic             accept;

    assign last_pair     = (pair_count_reg == LAST_PAIR);
    assign samples.ready = !last_pair || s1_adv;
    assign accept        = samples.valid && samples.ready;
    assign pos_sum       = pos_total_reg + TOT_W'(samples.pos_sample);
    assign gain_sum      = gain_total_reg + TOT_W'(samples.gain_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_total_reg  <= '0;
            gain_total_reg <= '0;
            pair_count_reg <= '0;
        end
        else if (accept)
        begin
            if (last_pair)
            begin
                pos_total_reg  <= '0;
                gain_total_reg <= '0;
                pair_count_reg <= '0;
            end
            else
            begin
                pos_total_reg  <= pos_sum;
                gain_total_reg <= gain_sum;
                pair_count_reg <= pair_count_reg + 1'b1;
            end
        end
    end

    // Stage 1: the completed group totals.
    logic [TOT_W-1:0] s1_pos_reg, s1_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept && last_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_pair)
        begin
            s1_pos_reg  <= pos_sum;
            s1_gain_reg <= gain_sum;
        end
    end

    // Stage 2: floored averages through the reciprocal multiply.
    logic [AVG_P_W-1:0]           pos_avg_prod, gain_avg_prod;
    logic [pss_pkg::SAMPLE_W-1:0] s2_pos_reg, s2_gain_reg;

    assign pos_avg_prod  = AVG_P_W'(s1_pos_reg) * AVG_P_W'(AVG_RECIP);
    assign gain_avg_prod = AVG_P_W'(s1_gain_reg) * AVG_P_W'(AVG_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_pos_reg  <= pos_avg_prod[AVG_SHIFT +: pss_pkg::SAMPLE_W];
            s2_gain_reg <= gain_avg_prod[AVG_SHIFT +: pss_pkg::SAMPLE_W];
        end
    end

    // Stage 3: LED bar update and the gain times position-excess product.
    // A position at or below the offset gives a zero excess and so zero speed.
    logic                         led_update;
    pss_pkg::led_status_t         led_status;
    logic [pss_pkg::SAMPLE_W-1:0] pos_excess;
    logic [pss_pkg::PROD_W-1:0]   speed_prod;
    logic [pss_pkg::SAMPLE_W-1:0] s3_pos_reg, s3_gain_reg;
    logic [pss_pkg::PROD_W-1:0]   s3_prod_reg;
    pss_pkg::led_status_t         s3_led_reg;

    assign led_update = s3_adv && s2_valid_reg;
    assign pos_excess = (s2_pos_reg > zero_offset_reg) ? (s2_pos_reg - zero_offset_reg) : '0;
    assign speed_prod = pss_pkg::PROD_W'(s2_gain_reg[pss_pkg::SAMPLE_W-1:2])
                      * pss_pkg::PROD_W'(pos_excess);

    pss_led_bar u_led_bar
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (led_update),
        .pos_average (s2_pos_reg),
        .levels      (levels_reg),
        .status      (led_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (led_update)
        begin
            s3_pos_reg  <= s2_pos_reg;
            s3_gain_reg <= s2_gain_reg;
            s3_prod_reg <= speed_prod;
            s3_led_reg  <= led_status;
        end
    end

    // Stage 4: divide by 212 through its reciprocal, then saturate at 255.
    logic [SP_P_W-1:0]             speed_recip_prod;
    logic [pss_pkg::SPEED_Q_W-1:0] speed_quot;
    logic [pss_pkg::SPEED_W-1:0]   speed_clamped;
    logic [pss_pkg::SAMPLE_W-1:0]  s4_pos_reg, s4_gain_reg;
    logic [pss_pkg::SPEED_W-1:0]   s4_speed_reg;
    pss_pkg::led_status_t          s4_led_reg;

    assign speed_recip_prod = SP_P_W'(s3_prod_reg) * SP_P_W'(pss_pkg::SPEED_RECIP);
    assign speed_quot       = speed_recip_prod[pss_pkg::SPEED_SHIFT +: pss_pkg::SPEED_Q_W];
    assign speed_clamped    = (speed_quot > pss_pkg::SPEED_Q_W'(pss_pkg::SPEED_MAX))
                            ? pss_pkg::SPEED_MAX : speed_quot[pss_pkg::SPEED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_adv && s3_valid_reg)
        begin
            s4_pos_reg   <= s3_pos_reg;
            s4_gain_reg  <= s3_gain_reg;
            s4_speed_reg <= speed_clamped;
            s4_led_reg   <= s3_led_reg;
        end
    end

    // Output register: servo compare value, 50 plus speed scaled to 0..35.
    logic [SV_P_W-1:0]            servo_prod;
    logic [pss_pkg::SERVO_W-1:0]  servo_value;
    logic [pss_pkg::SAMPLE_W-1:0] out_pos_reg, out_gain_reg;
    logic [pss_pkg::SPEED_W-1:0]  out_speed_reg;
    logic [pss_pkg::SERVO_W-1:0]  out_servo_reg;
    pss_pkg::led_status_t         out_led_reg;

    assign servo_prod  = SV_P_W'(s4_speed_reg) * SV_P_W'(pss_pkg::SERVO_RECIP);
    assign servo_value = pss_pkg::SERVO_BASE
                       + pss_pkg::SERVO_W'(servo_prod[pss_pkg::SERVO_SHIFT +:
                                                      pss_pkg::SERVO_Q_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s4_valid_reg)
        begin
            out_pos_reg   <= s4_pos_reg;
            out_gain_reg  <= s4_gain_reg;
            out_speed_reg <= s4_speed_reg;
            out_servo_reg <= servo_value;
            out_led_reg   <= s4_led_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.pos_average   = out_pos_reg;
    assign results.gain_average  = out_gain_reg;
    assign results.speed_duty    = out_speed_reg;
    assign results.servo_compare = out_servo_reg;
    assign results.led_bits      = out_led_reg.bits;
    assign results.alarm_blink   = out_led_reg.alarm;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= LAST_PAIR)
        else $error("pair count passed the group size");

    a_ready_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        !last_pair |-> samples.ready)
        else $error("item refused before the group was complete");

    a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.servo_compare >= pss_pkg::SERVO_BASE)
                       && (results.servo_compare <= pss_pkg::SERVO_TOP))
        else $error("servo compare value out of range");

    a_result_follows_group: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !$past(s1_valid_reg)) |-> $past(accept && last_pair))
        else $error("group totals staged without a closing item");

endmodule

// ----- src/pss_led_bar.sv -----
`timescale 1ns / 1ps

module pss_led_bar
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic [pss_pkg::SAMPLE_W-1:0]  pos_average,
    input  pss_pkg::levels_t              levels,
    output pss_pkg::led_status_t          status
);

    logic [pss_pkg::LED_W-1:0] led_state_reg;
    logic [pss_pkg::LED_W-1:0] led_state_next;
    logic                      alarm;

    // Clear first, then the sticky sets, then the alarm wipes everything.
    always_comb
    begin
        led_state_next = led_state_reg;
        alarm          = 1'b0;
        if (pos_average > levels.clear_level)
        begin
            led_state_next = '0;
        end
        if (pos_average < levels.first_level)
        begin
            led_state_next[0] = 1'b1;
        end
        if (pos_average < levels.second_level)
        begin
            led_state_next[1] = 1'b1;
        end
        if (pos_average < levels.third_level)
        begin
            led_state_next[2] = 1'b1;
        end
        if (pos_average < levels.alarm_level)
        begin
            alarm          = 1'b1;
            led_state_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_state_reg <= '0;
        end
        else if (update)
        begin
            led_state_reg <= led_state_next;
        end
    end

    assign status.bits  = led_state_next;
    assign status.alarm = alarm;

    a_alarm_clears_bits: assert property (@(posedge clk) disable iff (!rst_n)
        status.alarm |-> (status.bits == '0))
        else $error("alarm raised with LED bits still set");

endmodule
